/* rtl/ffbp_pkg.sv */
// ----------------------------------------------------------------------------
// ffbp_pkg
// Shared types and constants of the first-fit bin packer: job and result
// beats, the bin table entry, status codes, register indexes and the FSM.
// ----------------------------------------------------------------------------
package ffbp_pkg;

	// Table depth and the number of machines with a capacity register.
	localparam int BIN_DEPTH    = 64;
	localparam int MAX_MACHINES = 6;

	localparam int SIZE_W  = 12;
	localparam int MACH_W  = 3;
	localparam int ROUND_W = 6;
	localparam int REG_W   = 12;
	localparam int REGIDX_W = 3;

	// Configuration register indexes.
	localparam logic [REGIDX_W-1:0] REG_USE_PREF      = 3'd0;
	localparam logic [REGIDX_W-1:0] REG_MACHINE_COUNT = 3'd1;
	localparam logic [REGIDX_W-1:0] REG_CAP_M0        = 3'd2;
	localparam logic [REGIDX_W-1:0] REG_CAP_M1        = 3'd3;
	localparam logic [REGIDX_W-1:0] REG_CAP_M2        = 3'd4;
	localparam logic [REGIDX_W-1:0] REG_CAP_M3        = 3'd5;
	localparam logic [REGIDX_W-1:0] REG_CAP_M4        = 3'd6;
	localparam logic [REGIDX_W-1:0] REG_CAP_M5        = 3'd7;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_PLACED     = 2'd0,
		STATUS_TOO_LARGE  = 2'd1,
		STATUS_TABLE_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic              new_batch;
		logic [SIZE_W-1:0] job_size;
		logic [MACH_W-1:0] preferred_machine;
	} job_t;

	typedef struct packed {
		logic [ROUND_W-1:0] round_index;
		logic [MACH_W-1:0]  machine_index;
		logic               bin_closed;
		status_t            status;
	} result_t;

	// One bin of the table as held in memory.
	typedef struct packed {
		logic               open;
		logic [SIZE_W-1:0]  room;
		logic [MACH_W-1:0]  machine;
		logic [ROUND_W-1:0] round;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_NEW,
		ST_FILL
	} state_t;

endpackage

/* rtl/first_fit_bin_packer_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_bin_packer_unit
// Online first-fit placement of jobs into per-machine bins, with the bin
// table held in a synchronous memory with one read and one write port.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                          Direction  Beat taken when
//   job       start, busy, job                 in         start && !busy
//   result    done, result                     out        done (one cycle)
//   config    cfg_we, cfg_index, cfg_data      in         cfg_we
//
// An item makes one search pass over the table (or two, with the preferred-
// machine pass first; a new batch or an empty table skips the search), then
// updates the chosen bin, or checks a fresh round and writes one entry per
// machine of it. The result beat is registered after the last of these
// steps; a search pass issues one table read per cycle.
// Reset clears the control registers and the fill count; the table memory
// itself is not cleared, as only entries below the fill count are read.
// The receiver cannot stall: done pulses for one cycle with the result.
//
module first_fit_bin_packer_unit #(
	parameter int MAX_BINS = ffbp_pkg::BIN_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  ffbp_pkg::job_t                  job,
	output logic                            done,
	output ffbp_pkg::result_t               result,
	input  logic                            cfg_we,
	input  logic [ffbp_pkg::REGIDX_W-1:0]   cfg_index,
	input  logic [ffbp_pkg::REG_W-1:0]      cfg_data
);

	localparam int IDX_W = $clog2(MAX_BINS);
	localparam int CNT_W = IDX_W + 1;
	localparam int NM    = ffbp_pkg::MAX_MACHINES;
	localparam int SW    = ffbp_pkg::SIZE_W;
	localparam int MW    = ffbp_pkg::MACH_W;
	localparam int RW    = ffbp_pkg::ROUND_W;

	// Configuration registers.
	logic          use_pref_q;
	logic [MW-1:0] machine_count_q;
	logic [SW-1:0] cap_q [NM];

	// Control state.
	ffbp_pkg::state_t state_q, state_d;
	ffbp_pkg::job_t   job_q;
	logic [CNT_W-1:0] bins_used_q;
	logic [RW-1:0]    next_round_q;
	logic [CNT_W-1:0] addr_q;
	logic             pass_pref_q;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	ffbp_pkg::entry_t rd_data_s1;
	logic [IDX_W-1:0] sel_q;
	ffbp_pkg::entry_t upd_q;
	logic [CNT_W-1:0] fill_base_q;
	logic [RW-1:0]    fill_round_q;
	logic [MW-1:0]    fill_k_q;
	logic [MW-1:0]    pick_q;
	logic             done_q;
	ffbp_pkg::result_t result_q;

	// Bin table.
	ffbp_pkg::entry_t mem [MAX_BINS];

	// Combinational control.
	logic             accept;
	logic [MW-1:0]    m_eff;
	logic             issue;
	logic             hit;
	logic             pass_end;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	ffbp_pkg::entry_t mem_wdata;
	logic [SW-1:0]    upd_room;
	logic [CNT_W-1:0] used_eff;
	logic [RW-1:0]    nr_eff;
	logic [CNT_W:0]   need_bins;
	logic             table_full;
	logic [NM-1:0]    fit_vec;
	logic             any_fit;
	logic             pref_fit;
	logic [MW-1:0]    pick;
	logic [SW-1:0]    cap_fill;
	logic [SW-1:0]    cap_pick;
	logic [SW-1:0]    fill_room;
	logic             fill_last;

	assign accept = start && !busy;
	assign busy   = (state_q != ffbp_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Effective machine count: zero counts as one, clamp to the register set.
	always_comb begin
		if (machine_count_q == '0) begin
			m_eff = MW'(1);
		end else if (machine_count_q > MW'(NM)) begin
			m_eff = MW'(NM);
		end else begin
			m_eff = machine_count_q;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_pref_q      <= 1'b0;
			machine_count_q <= MW'(1);
			for (int k = 0; k < NM; k++) begin
				cap_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				ffbp_pkg::REG_USE_PREF:      use_pref_q      <= cfg_data[0];
				ffbp_pkg::REG_MACHINE_COUNT: machine_count_q <= cfg_data[MW-1:0];
				ffbp_pkg::REG_CAP_M0:        cap_q[0]        <= cfg_data[SW-1:0];
				ffbp_pkg::REG_CAP_M1:        cap_q[1]        <= cfg_data[SW-1:0];
				ffbp_pkg::REG_CAP_M2:        cap_q[2]        <= cfg_data[SW-1:0];
				ffbp_pkg::REG_CAP_M3:        cap_q[3]        <= cfg_data[SW-1:0];
				ffbp_pkg::REG_CAP_M4:        cap_q[4]        <= cfg_data[SW-1:0];
				ffbp_pkg::REG_CAP_M5:        cap_q[5]        <= cfg_data[SW-1:0];
				default: ;
			endcase
		end
	end

	// Fit check across the machines of a fresh round, preferred machine first.
	always_comb begin
		pick     = '0;
		any_fit  = 1'b0;
		pref_fit = 1'b0;
		cap_fill = '0;
		cap_pick = '0;
		for (int k = 0; k < NM; k++) begin
			fit_vec[k] = (MW'(k) < m_eff) && (cap_q[k] >= job_q.job_size);
		end
		for (int k = NM - 1; k >= 0; k--) begin
			if (fit_vec[k]) begin
				pick    = MW'(k);
				any_fit = 1'b1;
			end
		end
		for (int k = 0; k < NM; k++) begin
			if (use_pref_q && fit_vec[k] && (job_q.preferred_machine == MW'(k))) begin
				pref_fit = 1'b1;
			end
			if (fill_k_q == MW'(k)) begin
				cap_fill = cap_q[k];
			end
			if (pick_q == MW'(k)) begin
				cap_pick = cap_q[k];
			end
		end
		if (pref_fit) begin
			pick = job_q.preferred_machine;
		end
	end

	// Table base and round for a new round; a new batch starts from empty.
	assign used_eff   = job_q.new_batch ? '0 : bins_used_q;
	assign nr_eff     = job_q.new_batch ? '0 : next_round_q;
	assign need_bins  = (CNT_W+1)'(used_eff) + (CNT_W+1)'(m_eff);
	assign table_full = need_bins > (CNT_W+1)'(MAX_BINS);

	// Scan: one read issued per cycle, its data checked in the cycle after.
	assign hit = rd_valid_s1 && rd_data_s1.open
		&& (rd_data_s1.room >= job_q.job_size)
		&& (!pass_pref_q || (rd_data_s1.machine == job_q.preferred_machine));
	assign issue    = (state_q == ffbp_pkg::ST_SCAN) && (addr_q < bins_used_q) && !hit;
	assign pass_end = (state_q == ffbp_pkg::ST_SCAN) && !issue && !rd_valid_s1;

	assign upd_room  = upd_q.room - job_q.job_size;
	assign fill_room = (fill_k_q == pick_q) ? (cap_fill - job_q.job_size) : cap_fill;
	assign fill_last = (fill_k_q == m_eff - MW'(1));

	// Next state and memory write port.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = sel_q;
		mem_wdata = upd_q;
		case (state_q)
			ffbp_pkg::ST_IDLE: begin
				if (accept) begin
					if (job.new_batch || (bins_used_q == '0)) begin
						state_d = ffbp_pkg::ST_NEW;
					end else begin
						state_d = ffbp_pkg::ST_SCAN;
					end
				end
			end
			ffbp_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = ffbp_pkg::ST_UPDATE;
				end else if (pass_end && !pass_pref_q) begin
					state_d = ffbp_pkg::ST_NEW;
				end
			end
			ffbp_pkg::ST_UPDATE: begin
				mem_we         = 1'b1;
				mem_wdata.room = upd_room;
				mem_wdata.open = (upd_room != '0);
				state_d        = ffbp_pkg::ST_IDLE;
			end
			ffbp_pkg::ST_NEW: begin
				if (!any_fit || table_full) begin
					state_d = ffbp_pkg::ST_IDLE;
				end else begin
					state_d = ffbp_pkg::ST_FILL;
				end
			end
			ffbp_pkg::ST_FILL: begin
				mem_we            = 1'b1;
				mem_waddr         = IDX_W'(fill_base_q + CNT_W'(fill_k_q));
				mem_wdata.open    = (fill_k_q != pick_q) || (fill_room != '0);
				mem_wdata.room    = fill_room;
				mem_wdata.machine = fill_k_q;
				mem_wdata.round   = fill_round_q;
				if (fill_last) begin
					state_d = ffbp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffbp_pkg::ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffbp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Bin table: one write and one registered read per cycle. Writes happen
	// only after the scan of the same item is over, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[addr_q[IDX_W-1:0]];
		rd_idx_s1  <= addr_q[IDX_W-1:0];
	end

	// Sequencing registers, table fill count and result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_used_q  <= '0;
			next_round_q <= '0;
			addr_q       <= '0;
			pass_pref_q  <= 1'b0;
			rd_valid_s1  <= 1'b0;
			done_q       <= 1'b0;
			fill_k_q     <= '0;
		end else begin
			rd_valid_s1 <= issue;
			// The result beat follows an update, a refused round or the last fill.
			done_q      <= (state_q == ffbp_pkg::ST_UPDATE)
				|| ((state_q == ffbp_pkg::ST_NEW) && (!any_fit || table_full))
				|| ((state_q == ffbp_pkg::ST_FILL) && fill_last);
			if (issue) begin
				addr_q <= addr_q + CNT_W'(1);
			end
			case (state_q)
				ffbp_pkg::ST_IDLE: begin
					if (accept) begin
						addr_q      <= '0;
						pass_pref_q <= use_pref_q && (job.preferred_machine < m_eff);
					end
				end
				ffbp_pkg::ST_SCAN: begin
					if (pass_end && pass_pref_q) begin
						pass_pref_q <= 1'b0;
						addr_q      <= '0;
					end
				end
				ffbp_pkg::ST_NEW: begin
					fill_k_q <= '0;
				end
				ffbp_pkg::ST_FILL: begin
					fill_k_q <= fill_k_q + MW'(1);
					if (fill_last) begin
						bins_used_q  <= CNT_W'(fill_base_q + CNT_W'(m_eff));
						next_round_q <= fill_round_q + RW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers: latched job, chosen entry, round set-up and result.
	always_ff @(posedge clk) begin
		if (accept) begin
			job_q <= job;
		end
		if (hit && (state_q == ffbp_pkg::ST_SCAN)) begin
			sel_q <= rd_idx_s1;
			upd_q <= rd_data_s1;
		end
		case (state_q)
			ffbp_pkg::ST_UPDATE: begin
				result_q.round_index   <= upd_q.round;
				result_q.machine_index <= upd_q.machine;
				result_q.bin_closed    <= (upd_room == '0);
				result_q.status        <= ffbp_pkg::STATUS_PLACED;
			end
			ffbp_pkg::ST_NEW: begin
				fill_base_q            <= used_eff;
				fill_round_q           <= nr_eff;
				pick_q                 <= pick;
				result_q.round_index   <= '0;
				result_q.machine_index <= '0;
				result_q.bin_closed    <= 1'b0;
				if (!any_fit) begin
					result_q.status <= ffbp_pkg::STATUS_TOO_LARGE;
				end else begin
					result_q.status <= ffbp_pkg::STATUS_TABLE_FULL;
				end
			end
			ffbp_pkg::ST_FILL: begin
				result_q.round_index   <= fill_round_q;
				result_q.machine_index <= pick_q;
				result_q.bin_closed    <= (cap_pick == job_q.job_size);
				result_q.status        <= ffbp_pkg::STATUS_PLACED;
			end
			default: ;
		endcase
	end

	// The result beat is only shown once the block has gone back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// An accepted job always makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted job did not start");

	// The fill count never passes the table depth.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bins_used_q <= CNT_W'(MAX_BINS))
		else $error("bin table overfilled");

	// The table is never written while a scan is reading it.
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ffbp_pkg::ST_UPDATE || state_q == ffbp_pkg::ST_FILL))
		else $error("table write outside update or fill");

	// A bin chosen by the scan always has room for the job.
	a_update_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffbp_pkg::ST_UPDATE) |-> (upd_q.room >= job_q.job_size))
		else $error("chosen bin lacks room");

endmodule
